// File: hw/rtl/motl_pkg.sv
// ----------------------------------------------------------------------------
// Memory order table lookup: shared definitions
// Table geometry, field widths, operation and result codes, entry layout,
// the request/response structs between the top level and the table store,
// and the ordering decision.
// ----------------------------------------------------------------------------
package motl_pkg;

    // Table geometry
    localparam int MAX_ENTRIES = 4096;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Field widths
    localparam int PC_W    = 64;
    localparam int CLASS_W = 8;
    localparam int FLAGS_W = 8;

    // Operation codes
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOT_ASC = 2'd2;

    // Order codes
    localparam logic [1:0] ORDER_TSO    = 2'd0;
    localparam logic [1:0] ORDER_ATOMIC = 2'd1;
    localparam logic [1:0] ORDER_RELAX  = 2'd2;

    // Memory classes and flag bit positions
    localparam logic [CLASS_W-1:0] CLASS_LOCAL  = 8'd1;
    localparam logic [CLASS_W-1:0] CLASS_ATOMIC = 8'd3;
    localparam int FLAG_ESCAPED_BIT = 0;
    localparam int FLAG_GUARD_BIT   = 1;

    typedef struct packed {
        logic [PC_W-1:0]    pc;
        logic [CLASS_W-1:0] cls;
        logic [FLAGS_W-1:0] flg;
    } t_entry;

    // Table write from the append path
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        t_entry           data;
    } t_wr_req;

    // Search request: key and number of valid entries
    typedef struct packed {
        logic             go;
        logic [PC_W-1:0]  key;
        logic [CNT_W-1:0] count;
    } t_srch_req;

    // Search response, one-cycle done pulse
    typedef struct packed {
        logic               done;
        logic               hit;
        logic [CLASS_W-1:0] cls;
        logic [FLAGS_W-1:0] flg;
    } t_srch_rsp;

    function automatic logic [1:0] choose_order(
        input logic [CLASS_W-1:0] cls,
        input logic [FLAGS_W-1:0] flg,
        input logic               guard_ok
    );
        logic [1:0] ord;
        ord = ORDER_TSO;
        if (cls == CLASS_ATOMIC) begin
            ord = ORDER_ATOMIC;
        end else if (cls == CLASS_LOCAL) begin
            if (flg[FLAG_ESCAPED_BIT]) begin
                ord = ORDER_TSO;
            end else if (!flg[FLAG_GUARD_BIT] || guard_ok) begin
                ord = ORDER_RELAX;
            end else begin
                ord = ORDER_TSO;
            end
        end
        return ord;
    endfunction

endpackage

// File: hw/rtl/motl_store.sv
// ----------------------------------------------------------------------------
// Memory order table lookup: table store and search engine
// Holds the sorted entry table in one synchronous RAM and runs the binary
// search; each probe issues the read, then compares.
// ----------------------------------------------------------------------------
module motl_store (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  motl_pkg::t_wr_req   i_wr,
    input  motl_pkg::t_srch_req i_req,
    output motl_pkg::t_srch_rsp o_rsp
);
    import motl_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK
    } t_state;

    t_entry           mem [MAX_ENTRIES];
    t_entry           r_rdata;

    t_state           r_state;
    logic [CNT_W-1:0] r_lo;
    logic [CNT_W-1:0] r_hi;
    logic [IDX_W-1:0] r_mid;
    logic [PC_W-1:0]  r_key;
    t_srch_rsp        r_rsp;

    logic [CNT_W:0]   mid_sum;
    logic [IDX_W-1:0] mid;
    logic [CNT_W-1:0] mid_ext;
    logic [CNT_W-1:0] n_lo;
    logic [CNT_W-1:0] n_hi;

    // Midpoint of the open range; always below hi, so it fits an index
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[IDX_W:1];
    assign mid_ext = CNT_W'(r_mid);

    // Narrow the range from the compare of the probed entry
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (r_rdata.pc < r_key) begin
            n_lo = mid_ext + CNT_W'(1);
        end else begin
            n_hi = mid_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PROBE) begin
            r_rdata <= mem[mid];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rsp.done <= 1'b0;
        end else begin
            r_rsp.done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.go) begin
                        r_lo  <= '0;
                        r_hi  <= i_req.count;
                        r_key <= i_req.key;
                        if (i_req.count == '0) begin
                            r_rsp.done <= 1'b1;
                            r_rsp.hit  <= 1'b0;
                            r_rsp.cls  <= '0;
                            r_rsp.flg  <= '0;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    r_mid   <= mid;
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_rdata.pc == r_key) begin
                        r_rsp.done <= 1'b1;
                        r_rsp.hit  <= 1'b1;
                        r_rsp.cls  <= r_rdata.cls;
                        r_rsp.flg  <= r_rdata.flg;
                        r_state    <= S_IDLE;
                    end else if (n_lo < n_hi) begin
                        r_lo    <= n_lo;
                        r_hi    <= n_hi;
                        r_state <= S_PROBE;
                    end else begin
                        r_rsp.done <= 1'b1;
                        r_rsp.hit  <= 1'b0;
                        r_rsp.cls  <= '0;
                        r_rsp.flg  <= '0;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: hw/rtl/memory_order_table_lookup_unit.sv
// ----------------------------------------------------------------------------
// Memory order table lookup unit
// Sorted table of guest program counters with memory class and flags;
// clear, append and binary-search query giving a memory-ordering decision.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive the request fields and raise start; the request
//   is taken at a rising edge where start is high and busy is low.
//   Result channel: every request gives exactly one result, shown on the
//   o_ ports for one cycle while o_done is high. The receiver cannot stall,
//   so capture it in that cycle.
//   Latency: clear, append and unused opcodes answer in the cycle after the
//   request and never raise busy, so they may follow each other every cycle.
//   A query raises busy and answers once the search has run P probes, where
//   P is at most ceil(log2(n+1)) for n valid entries (13 for a full
//   4096-entry table); the result is then registered. Each probe costs one
//   synchronous read of the table RAM plus one 64-bit compare.
//   Reset (i_rst_n low, synchronous) empties the table and the last
//   program counter; the RAM itself is not swept, entries above the fill
//   count are never read.
// ----------------------------------------------------------------------------
module memory_order_table_lookup_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    i_opcode,
    input  logic [motl_pkg::PC_W-1:0]     i_pc,
    input  logic [motl_pkg::CLASS_W-1:0]  i_mem_class,
    input  logic [motl_pkg::FLAGS_W-1:0]  i_entry_flags,
    input  logic                          i_guard_ok,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic                          o_found,
    output logic [1:0]                    o_order,
    output logic [motl_pkg::CLASS_W-1:0]  o_hit_class,
    output logic [motl_pkg::FLAGS_W-1:0]  o_hit_flags
);
    import motl_pkg::*;

    typedef enum logic {
        T_IDLE,
        T_SEARCH
    } t_state;

    t_state           r_state;
    logic             r_busy;
    logic             r_done;
    logic [1:0]       r_status;
    logic             r_found;
    logic [1:0]       r_order;
    logic [CLASS_W-1:0] r_hit_class;
    logic [FLAGS_W-1:0] r_hit_flags;
    logic             r_guard;

    logic [CNT_W-1:0] r_count;
    logic [PC_W-1:0]  r_last_pc;

    logic             accept;
    logic             tbl_full;
    logic             not_asc;
    t_wr_req          wr;
    t_srch_req        req;
    t_srch_rsp        rsp;

    assign accept   = start && !r_busy;
    // Full check goes first, then the ascending rule
    assign tbl_full = (r_count == CNT_W'(MAX_ENTRIES));
    assign not_asc  = (r_count != '0) && (i_pc <= r_last_pc);

    // Append writes the entry at the fill count
    assign wr.en       = accept && (i_opcode == OP_APPEND) && !tbl_full && !not_asc;
    assign wr.addr     = r_count[IDX_W-1:0];
    assign wr.data.pc  = i_pc;
    assign wr.data.cls = i_mem_class;
    assign wr.data.flg = i_entry_flags;

    // Query hands the key and the current fill count to the search engine
    assign req.go    = accept && (i_opcode == OP_QUERY);
    assign req.key   = i_pc;
    assign req.count = r_count;

    motl_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_busy    <= 1'b0;
            r_done    <= 1'b0;
            r_count   <= '0;
            r_last_pc <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                T_IDLE: begin
                    if (accept) begin
                        // Default result: all fields zero
                        r_status    <= ST_OK;
                        r_found     <= 1'b0;
                        r_order     <= ORDER_TSO;
                        r_hit_class <= '0;
                        r_hit_flags <= '0;
                        r_guard     <= i_guard_ok;
                        case (i_opcode)
                            OP_CLEAR: begin
                                r_count   <= '0;
                                r_last_pc <= '0;
                                r_done    <= 1'b1;
                            end
                            OP_APPEND: begin
                                if (tbl_full) begin
                                    r_status <= ST_FULL;
                                end else if (not_asc) begin
                                    r_status <= ST_NOT_ASC;
                                end else begin
                                    r_count   <= r_count + CNT_W'(1);
                                    r_last_pc <= i_pc;
                                end
                                r_done <= 1'b1;
                            end
                            OP_QUERY: begin
                                // Hold off new requests until the search ends
                                r_busy  <= 1'b1;
                                r_state <= T_SEARCH;
                            end
                            default: begin
                                // Unused opcode: drop, answer zero
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                T_SEARCH: begin
                    if (rsp.done) begin
                        r_found     <= rsp.hit;
                        r_hit_class <= rsp.cls;
                        r_hit_flags <= rsp.flg;
                        r_order     <= rsp.hit ? choose_order(rsp.cls, rsp.flg, r_guard)
                                               : ORDER_TSO;
                        r_done      <= 1'b1;
                        r_busy      <= 1'b0;
                        r_state     <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy        = r_busy;
    assign o_done      = r_done;
    assign o_status    = r_status;
    assign o_found     = r_found;
    assign o_order     = r_order;
    assign o_hit_class = r_hit_class;
    assign o_hit_flags = r_hit_flags;

endmodule

// File: dv/motl_checker.sv
// ----------------------------------------------------------------------------
// Memory order table lookup: response checker
// Watches the request and result channels, keeps a private copy of the
// sorted table, works out the decision for every accepted request and
// compares each result field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module motl_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic                          i_busy,
    input  logic [1:0]                    i_opcode,
    input  logic [motl_pkg::PC_W-1:0]     i_pc,
    input  logic [motl_pkg::CLASS_W-1:0]  i_mem_class,
    input  logic [motl_pkg::FLAGS_W-1:0]  i_entry_flags,
    input  logic                          i_guard_ok,
    input  logic                          i_done,
    input  logic [1:0]                    i_status,
    input  logic                          i_found,
    input  logic [1:0]                    i_order,
    input  logic [motl_pkg::CLASS_W-1:0]  i_hit_class,
    input  logic [motl_pkg::FLAGS_W-1:0]  i_hit_flags,
    output int                            o_mismatches,
    output int                            o_pending,
    output int                            o_hits,
    output int                            o_full_rejects,
    output int                            o_order_rejects
);
    import motl_pkg::*;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic [1:0]         order;
        logic [CLASS_W-1:0] hit_class;
        logic [FLAGS_W-1:0] hit_flags;
    } t_lookup_rsp;

    logic [PC_W-1:0]    tbl_pc  [MAX_ENTRIES];
    logic [CLASS_W-1:0] tbl_cls [MAX_ENTRIES];
    logic [FLAGS_W-1:0] tbl_flg [MAX_ENTRIES];
    int unsigned        tbl_used;
    logic [PC_W-1:0]    tbl_last;

    t_lookup_rsp        pending_decisions [$];
    int                 mismatch_cnt;
    int                 hit_cnt;
    int                 full_cnt;
    int                 not_asc_cnt;

    // Update the table copy for one request and return the decision it gives.
    function automatic t_lookup_rsp apply_request(
        input logic [1:0]         op,
        input logic [PC_W-1:0]    key,
        input logic [CLASS_W-1:0] cls,
        input logic [FLAGS_W-1:0] flg,
        input logic               guard
    );
        t_lookup_rsp rsp;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned at;
        logic        hit;
        rsp = '0;
        case (op)
            OP_CLEAR: begin
                tbl_used = 0;
                tbl_last = '0;
            end
            OP_APPEND: begin
                if (tbl_used >= MAX_ENTRIES) begin
                    rsp.status = ST_FULL;
                    full_cnt++;
                end else if (tbl_used > 0 && key <= tbl_last) begin
                    rsp.status = ST_NOT_ASC;
                    not_asc_cnt++;
                end else begin
                    tbl_pc[tbl_used]  = key;
                    tbl_cls[tbl_used] = cls;
                    tbl_flg[tbl_used] = flg;
                    tbl_used++;
                    tbl_last   = key;
                    rsp.status = ST_OK;
                end
            end
            OP_QUERY: begin
                lo  = 0;
                hi  = tbl_used;
                at  = 0;
                hit = 1'b0;
                while (lo < hi && !hit) begin
                    mid = lo + (hi - lo) / 2;
                    if (tbl_pc[mid] == key) begin
                        hit = 1'b1;
                        at  = mid;
                    end else if (tbl_pc[mid] < key) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                // A miss keeps the all-zero result, which is total store order.
                if (hit) begin
                    hit_cnt++;
                    rsp.found     = 1'b1;
                    rsp.hit_class = tbl_cls[at];
                    rsp.hit_flags = tbl_flg[at];
                    case (tbl_cls[at])
                        CLASS_ATOMIC: rsp.order = ORDER_ATOMIC;
                        CLASS_LOCAL: begin
                            if (tbl_flg[at][FLAG_ESCAPED_BIT]) begin
                                rsp.order = ORDER_TSO;
                            end else if (tbl_flg[at][FLAG_GUARD_BIT] && !guard) begin
                                rsp.order = ORDER_TSO;
                            end else begin
                                rsp.order = ORDER_RELAX;
                            end
                        end
                        default: rsp.order = ORDER_TSO;
                    endcase
                end
            end
            default: ;
        endcase
        return rsp;
    endfunction

    task automatic report_mismatch(
        input string           what,
        input logic [63:0]     got,
        input logic [63:0]     want
    );
        mismatch_cnt++;
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task automatic check_result();
        t_lookup_rsp want;
        if (pending_decisions.size() == 0) begin
            report_mismatch("result with no request outstanding", 64'(i_status), 64'd0);
            return;
        end
        want = pending_decisions.pop_front();
        if (i_status !== want.status) begin
            report_mismatch("status", 64'(i_status), 64'(want.status));
        end
        if (i_found !== want.found) begin
            report_mismatch("found", 64'(i_found), 64'(want.found));
        end
        if (i_order !== want.order) begin
            report_mismatch("order", 64'(i_order), 64'(want.order));
        end
        if (i_hit_class !== want.hit_class) begin
            report_mismatch("hit_class", 64'(i_hit_class), 64'(want.hit_class));
        end
        if (i_hit_flags !== want.hit_flags) begin
            report_mismatch("hit_flags", 64'(i_hit_flags), 64'(want.hit_flags));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tbl_used = 0;
            tbl_last = '0;
            pending_decisions.delete();
        end else begin
            if (i_done) begin
                check_result();
            end
            if (i_start && !i_busy) begin
                pending_decisions.push_back(apply_request(i_opcode, i_pc, i_mem_class,
                                                          i_entry_flags, i_guard_ok));
            end
        end
        o_mismatches    <= mismatch_cnt;
        o_pending       <= pending_decisions.size();
        o_hits          <= hit_cnt;
        o_full_rejects  <= full_cnt;
        o_order_rejects <= not_asc_cnt;
    end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// Memory order table lookup unit: testbench top
// Drives clear, append and query requests into the unit: a directed pass
// over the decision rules, then random table-building sequences under
// three pacing phases. The checker beside the unit does all prediction;
// this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import motl_pkg::*;

    // Opcode that the unit must ignore
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Cycles without any accepted request or result before giving up
    localparam int STALL_LIMIT = 2000;
    // Quiet cycles after the last result, above the deepest query latency
    localparam int DRAIN_CYCLES = 40;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [1:0]           i_opcode;
    logic [PC_W-1:0]      i_pc;
    logic [CLASS_W-1:0]   i_mem_class;
    logic [FLAGS_W-1:0]   i_entry_flags;
    logic                 i_guard_ok;
    logic                 o_done;
    logic [1:0]           o_status;
    logic                 o_found;
    logic [1:0]           o_order;
    logic [CLASS_W-1:0]   o_hit_class;
    logic [FLAGS_W-1:0]   o_hit_flags;

    int                   mismatches;
    int                   pending;
    int                   hits;
    int                   full_rejects;
    int                   order_rejects;

    // Sender pacing: chance in percent of a pause before each request
    int                   idle_pct;
    int                   n_requests;
    // Program counters the unit should now hold, in table order
    logic [PC_W-1:0]      live_pc [$];

    memory_order_table_lookup_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_pc          (i_pc),
        .i_mem_class   (i_mem_class),
        .i_entry_flags (i_entry_flags),
        .i_guard_ok    (i_guard_ok),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found       (o_found),
        .o_order       (o_order),
        .o_hit_class   (o_hit_class),
        .o_hit_flags   (o_hit_flags)
    );

    motl_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .i_busy          (busy),
        .i_opcode        (i_opcode),
        .i_pc            (i_pc),
        .i_mem_class     (i_mem_class),
        .i_entry_flags   (i_entry_flags),
        .i_guard_ok      (i_guard_ok),
        .i_done          (o_done),
        .i_status        (o_status),
        .i_found         (o_found),
        .i_order         (o_order),
        .i_hit_class     (o_hit_class),
        .i_hit_flags     (o_hit_flags),
        .o_mismatches    (mismatches),
        .o_pending       (pending),
        .o_hits          (hits),
        .o_full_rejects  (full_rejects),
        .o_order_rejects (order_rejects)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [PC_W-1:0] random64();
        return {$urandom, $urandom};
    endfunction

    // Mostly class values 0 to 3, now and then any byte value.
    function automatic logic [CLASS_W-1:0] pick_class();
        if ($urandom_range(4) == 0) begin
            return CLASS_W'($urandom);
        end
        return CLASS_W'($urandom_range(3));
    endfunction

    // Present one request and hold it until the unit takes it. Change inputs
    // only at the falling edge; scramble the fields while start is low so the
    // unit is seen to ignore them.
    task automatic issue(
        input logic [1:0]         op,
        input logic [PC_W-1:0]    key,
        input logic [CLASS_W-1:0] cls,
        input logic [FLAGS_W-1:0] flg,
        input logic               guard
    );
        int gap;
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start         <= 1'b0;
            i_opcode      <= 2'($urandom);
            i_pc          <= random64();
            i_mem_class   <= CLASS_W'($urandom);
            i_entry_flags <= FLAGS_W'($urandom);
            i_guard_ok    <= 1'($urandom);
            gap = $urandom_range(0, 5);
            repeat (gap) @(negedge i_clk);
        end
        @(negedge i_clk);
        start         <= 1'b1;
        i_opcode      <= op;
        i_pc          <= key;
        i_mem_class   <= cls;
        i_entry_flags <= flg;
        i_guard_ok    <= guard;
        // Accepted at the first rising edge that sees busy low.
        do @(posedge i_clk); while (busy);
        n_requests++;
    endtask

    task automatic clear_table();
        issue(OP_CLEAR, random64(), CLASS_W'($urandom), FLAGS_W'($urandom), 1'($urandom));
        live_pc.delete();
    endtask

    // Append and track what the unit should keep, so later queries can aim
    // at real entries.
    task automatic append_entry(
        input logic [PC_W-1:0]    key,
        input logic [CLASS_W-1:0] cls,
        input logic [FLAGS_W-1:0] flg
    );
        issue(OP_APPEND, key, cls, flg, 1'($urandom));
        if (live_pc.size() < MAX_ENTRIES && (live_pc.size() == 0 || key > live_pc[$])) begin
            live_pc.push_back(key);
        end
    endtask

    task automatic query(input logic [PC_W-1:0] key, input logic guard);
        issue(OP_QUERY, key, CLASS_W'($urandom), FLAGS_W'($urandom), guard);
    endtask

    // Watchdog: end the run when nothing moves on either channel for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (start && !busy) || o_done) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no request or result for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int              phase;
        int              counted;
        int              roll;
        int              idx;
        logic [PC_W-1:0] key;

        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_opcode      = OP_CLEAR;
        i_pc          = '0;
        i_mem_class   = '0;
        i_entry_flags = '0;
        i_guard_ok    = 1'b0;
        idle_pct      = 0;
        n_requests    = 0;

        // Hold reset, then release it on a falling edge.
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, one entry per decision rule, edge pcs.
        query('0, 1'b1);                            // lookup on an empty table
        append_entry('0, CLASS_LOCAL, 8'h00);       // pc zero accepted when empty
        append_entry('0, CLASS_LOCAL, 8'h00);       // equal pc: not ascending
        query('0, 1'b0);                            // local, no guard: relaxed
        append_entry(64'd1, CLASS_LOCAL, 8'h01);    // escaped
        append_entry(64'd2, CLASS_LOCAL, 8'h02);    // guard required
        append_entry(64'd3, CLASS_LOCAL, 8'h03);    // escaped and guarded
        append_entry(64'd4, CLASS_ATOMIC, 8'hFF);
        append_entry(64'd5, 8'd2, 8'h00);           // shared
        append_entry(64'd6, 8'd0, 8'hFC);           // unknown
        append_entry(64'd7, 8'hFF, 8'hFF);          // class outside the named set
        append_entry('1, CLASS_LOCAL, 8'h00);       // largest pc
        append_entry({PC_W{1'b1}} - 1, CLASS_LOCAL, 8'h00);  // below the last
        query(64'd1, 1'b1);
        query(64'd2, 1'b0);
        query(64'd2, 1'b1);
        query(64'd3, 1'b1);
        query(64'd4, 1'b0);
        query(64'd5, 1'b1);
        query(64'd7, 1'b0);
        query('1, 1'b0);
        query(64'd8, 1'b1);                         // miss between entries
        issue(OP_UNUSED, '1, '1, '1, 1'b1);         // unused opcode
        clear_table();
        query(64'd1, 1'b1);                         // miss after clear
        append_entry(64'd0, CLASS_ATOMIC, 8'h00);   // pc zero accepted: table empty after clear

        // Random table-building sequences under three pacing phases.
        for (phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 24 : (phase == 1) ? 78 : 0;
            counted  = 0;
            while (counted < 180) begin
                roll = $urandom_range(99);
                if (roll < 3) begin
                    clear_table();
                    counted++;
                end else if (roll < 36 || live_pc.size() == 0) begin
                    // Well-formed append; an empty table starts anywhere.
                    if (live_pc.size() == 0) begin
                        key = random64() >> $urandom_range(0, 63);
                    end else if ($urandom_range(7) == 0) begin
                        key = live_pc[$] + {32'b0, $urandom};
                    end else begin
                        key = live_pc[$] + $urandom_range(1, 16);
                    end
                    append_entry(key, pick_class(), FLAGS_W'($urandom));
                    counted++;
                end else if (roll < 72) begin
                    query(live_pc[$urandom_range(live_pc.size() - 1)], 1'($urandom));
                    counted++;
                end else if (roll < 86) begin
                    // Near misses beside live entries, or anywhere.
                    idx = $urandom_range(live_pc.size() - 1);
                    case ($urandom_range(2))
                        0:       key = random64();
                        1:       key = live_pc[idx] + 1;
                        default: key = live_pc[idx] - 1;
                    endcase
                    query(key, 1'($urandom));
                    counted++;
                end else if (roll < 93) begin
                    // Broken sequence: append at or below an existing entry.
                    key = live_pc[$urandom_range(live_pc.size() - 1)] - $urandom_range(0, 3);
                    append_entry(key, pick_class(), FLAGS_W'($urandom));
                    counted++;
                end else begin
                    issue(OP_UNUSED, random64(), CLASS_W'($urandom), FLAGS_W'($urandom),
                          1'($urandom));
                end
            end
        end

        // Drop start, drain outstanding results, then let the unit settle.
        @(negedge i_clk);
        start <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests: decision rules and three pacing phases.",
                 n_requests);
        $display("Lookups hit %0d, appends refused as full %0d and as out of order %0d.",
                 hits, full_rejects, order_rejects);
        if (mismatches == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
hw/rtl/motl_pkg.sv
hw/rtl/motl_store.sv
hw/rtl/memory_order_table_lookup_unit.sv
dv/motl_checker.sv
dv/tb_top.sv
